@@ rtl/ccsv_pkg.sv @@
// ----------------------------------------------------------------------------
// ccsv_pkg
// Types and constants for the CAFF/CIFF stream validator.
// ----------------------------------------------------------------------------
package ccsv_pkg;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_BHDR    = 4'd1,
        PH_HDRBLK  = 4'd2,
        PH_CREDITS = 4'd3,
        PH_CREATOR = 4'd4,
        PH_ANIM    = 4'd5,
        PH_CIFF    = 4'd6,
        PH_CAPTION = 4'd7,
        PH_TAGS    = 4'd8,
        PH_PIXELS  = 4'd9
    } phase_t;

    localparam logic [4:0] ST_BUSY        = 5'd0;
    localparam logic [4:0] ST_ACCEPTED    = 5'd1;
    localparam logic [4:0] ST_BAD_BLOCK   = 5'd2;
    localparam logic [4:0] ST_NOT_HEADER  = 5'd3;
    localparam logic [4:0] ST_DUP_HEADER  = 5'd4;
    localparam logic [4:0] ST_CAFF_MAGIC  = 5'd5;
    localparam logic [4:0] ST_CAFF_HSIZE  = 5'd6;
    localparam logic [4:0] ST_NO_ANIM     = 5'd7;
    localparam logic [4:0] ST_DATE        = 5'd8;
    localparam logic [4:0] ST_CREATOR     = 5'd9;
    localparam logic [4:0] ST_CIFF_MAGIC  = 5'd10;
    localparam logic [4:0] ST_CIFF_HSIZE  = 5'd11;
    localparam logic [4:0] ST_SIZE_MISM   = 5'd12;
    localparam logic [4:0] ST_SIZE_ZERO   = 5'd13;
    localparam logic [4:0] ST_NO_NEWLINE  = 5'd14;
    localparam logic [4:0] ST_TAG_NEWLINE = 5'd15;
    localparam logic [4:0] ST_TRUNC       = 5'd16;
    localparam logic [4:0] ST_IGNORED     = 5'd17;

    localparam logic [2:0] CL_HEADER  = 3'd0;
    localparam logic [2:0] CL_CREATOR = 3'd1;
    localparam logic [2:0] CL_CAPTION = 3'd2;
    localparam logic [2:0] CL_TAG     = 3'd3;
    localparam logic [2:0] CL_PIXEL   = 3'd4;
    localparam logic [2:0] CL_IGNORED = 3'd5;

    localparam logic [1:0] ID_HEADER  = 2'd1;
    localparam logic [1:0] ID_CREDITS = 2'd2;
    localparam logic [1:0] ID_ANIM    = 2'd3;

    localparam logic [31:0] CAFF_MAGIC = {8'h46, 8'h46, 8'h41, 8'h43};
    localparam logic [31:0] CIFF_MAGIC = {8'h46, 8'h46, 8'h49, 8'h43};
    localparam logic [7:0]  NEWLINE    = 8'h0A;

endpackage

@@ rtl/caff_ciff_stream_validator_core.sv @@
// ----------------------------------------------------------------------------
// caff_ciff_stream_validator_core
// Byte-serial validator for CAFF containers and bare CIFF images.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel (in_valid/in_ready): one file byte per transaction with
//    last_byte marking the final byte. out channel (out_valid/out_ready):
//    one result per input byte: status, byte_class, tag_end and the
//    decoded image width and height.
//  - cfg channel (cfg_valid/cfg_ready, cfg_data): file_mode, 0 = CAFF,
//    1 = bare CIFF. Write only while idle; sampled at the first byte.
//  - The result of a byte is registered and shows in the cycle after the
//    input transaction. Throughput: one byte per cycle unless the receiver
//    stalls; parse state and result register update in the same cycle.
//  - The 64x8 partial product of width*3 and one height byte is the
//    longest path; the height field is folded in one byte per cycle.
//  - Stall: in_ready is high whenever the output register is empty or is
//    being drained, so a stalled receiver holds the input back with one
//    result waiting.
//  - Reset clears the parse state, file_mode and the output valid.
//  - After last_byte the parser starts over with the next byte.
// ----------------------------------------------------------------------------
module caff_ciff_stream_validator_core
    import ccsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  status,
    output logic [2:0]  byte_class,
    output logic        tag_end,
    output logic [63:0] image_width,
    output logic [63:0] image_height,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    // parse state
    phase_t      phase_reg, phase_next;
    logic [5:0]  idx_reg, idx_next;
    logic [63:0] blen_reg, blen_next;
    logic [63:0] csize_reg, csize_next;
    logic [63:0] width_reg, width_next;
    logic [63:0] height_reg, height_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] left_reg, left_next;
    logic        hseen_reg, hseen_next;
    logic [1:0]  flags_reg, flags_next;
    logic [4:0]  verdict_reg, verdict_next;
    logic        mode_reg;

    // result register
    logic        ovalid_reg;
    logic [4:0]  status_reg, status_next;
    logic [2:0]  class_reg, class_next;
    logic        tend_reg, tend_next;
    logic [63:0] ow_reg, oh_reg;

    logic        take;
    phase_t      ph;
    logic [5:0]  k6;
    logic [2:0]  lane;
    logic [63:0] lane_val;
    logic [63:0] w3;
    logic [63:0] pp8;
    logic [63:0] pp;
    logic [63:0] left_dec;
    logic [15:0] year;

    assign in_ready  = !ovalid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign take      = in_valid && in_ready;

    assign out_valid    = ovalid_reg;
    assign status       = status_reg;
    assign byte_class   = class_reg;
    assign tag_end      = tend_reg;
    assign image_width  = ow_reg;
    assign image_height = oh_reg;

    // effective phase: a fresh file starts in the mode's first phase
    always_comb
    begin
        if (phase_reg == PH_START)
            ph = mode_reg ? PH_CIFF : PH_BHDR;
        else
            ph = phase_reg;
    end

    // lane of the current byte inside its 64-bit little-endian field
    always_comb
    begin
        unique case (ph)
            PH_BHDR:    k6 = idx_reg - 6'd1;
            PH_HDRBLK:  k6 = idx_reg - 6'd4;
            PH_CREDITS: k6 = idx_reg - 6'd6;
            default:    k6 = idx_reg - 6'd4;
        endcase
        lane     = k6[2:0];
        lane_val = {56'd0, data_byte} << {lane, 3'b000};
    end

    // width*3 times one height byte, then moved to the byte's lane
    assign w3       = width_reg + {width_reg[62:0], 1'b0};
    assign pp8      = 64'(w3 * data_byte);
    assign pp       = pp8 << {lane, 3'b000};
    assign left_dec = left_reg - 64'd1;
    assign year     = {data_byte, left_reg[7:0]};

    // byte class and tag terminator of the current byte
    always_comb
    begin
        class_next = CL_HEADER;
        tend_next  = 1'b0;
        if (verdict_reg != ST_BUSY) begin
            class_next = CL_IGNORED;
        end else begin
            unique case (ph)
                PH_CREATOR: class_next = CL_CREATOR;
                PH_CAPTION: class_next = CL_CAPTION;
                PH_TAGS:
                begin
                    class_next = CL_TAG;
                    tend_next  = (data_byte == 8'd0);
                end
                PH_PIXELS:  class_next = CL_PIXEL;
                default:    class_next = CL_HEADER;
            endcase
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        blen_next    = blen_reg;
        csize_next   = csize_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        prod_next    = prod_reg;
        left_next    = left_reg;
        hseen_next   = hseen_reg;
        flags_next   = flags_reg;
        verdict_next = verdict_reg;
        status_next  = ST_BUSY;

        if (verdict_reg != ST_BUSY) begin
            status_next = ST_IGNORED;
        end else begin
            if (phase_reg == PH_START) begin
                phase_next = ph;
                idx_next   = 6'd0;
                flags_next = 2'd0;
            end
            unique case (ph)
                PH_BHDR:
                begin
                    if (idx_reg == 6'd0) begin
                        flags_next = (data_byte >= 8'd1 && data_byte <= 8'd3)
                                     ? data_byte[1:0] : 2'd0;
                        idx_next   = idx_reg + 6'd1;
                    end else begin
                        blen_next = (lane == 3'd0) ? lane_val : (blen_reg | lane_val);
                        if (idx_reg < 6'd8) begin
                            idx_next = idx_reg + 6'd1;
                        end else if (!((flags_reg == ID_HEADER && blen_next == 64'd20) ||
                                       (flags_reg == ID_CREDITS && blen_next >= 64'd14) ||
                                       (flags_reg == ID_ANIM && blen_next >= 64'd42))) begin
                            verdict_next = ST_BAD_BLOCK;
                        end else if (!hseen_reg) begin
                            if (flags_reg != ID_HEADER) begin
                                verdict_next = ST_NOT_HEADER;
                            end else begin
                                hseen_next = 1'b1;
                                phase_next = PH_HDRBLK;
                                idx_next   = 6'd0;
                                flags_next = 2'd0;
                            end
                        end else if (flags_reg == ID_HEADER) begin
                            verdict_next = ST_DUP_HEADER;
                        end else begin
                            phase_next = (flags_reg == ID_CREDITS) ? PH_CREDITS : PH_ANIM;
                            idx_next   = 6'd0;
                            flags_next = 2'd0;
                        end
                    end
                end
                PH_HDRBLK:
                begin
                    if (idx_reg < 6'd4) begin
                        if (data_byte != CAFF_MAGIC[{idx_reg[1:0], 3'b000} +: 8])
                            flags_next[0] = 1'b1;
                    end else if (idx_reg < 6'd12) begin
                        left_next = (lane == 3'd0) ? lane_val : (left_reg | lane_val);
                    end else if (data_byte != 8'd0) begin
                        flags_next[1] = 1'b1;
                    end
                    if (idx_reg < 6'd19) begin
                        idx_next = idx_reg + 6'd1;
                    end else if (flags_next[0]) begin
                        verdict_next = ST_CAFF_MAGIC;
                    end else if (left_next != 64'd20) begin
                        verdict_next = ST_CAFF_HSIZE;
                    end else if (!flags_next[1]) begin
                        verdict_next = ST_NO_ANIM;
                    end else begin
                        phase_next = PH_BHDR;
                        idx_next   = 6'd0;
                        flags_next = 2'd0;
                    end
                end
                PH_CREDITS:
                begin
                    case (idx_reg)
                        6'd0: left_next = {56'd0, data_byte};
                        6'd1: if (year > 16'd9999) flags_next[0] = 1'b1;
                        6'd2: if (data_byte < 8'd1 || data_byte > 8'd12) flags_next[0] = 1'b1;
                        6'd3: if (data_byte < 8'd1 || data_byte > 8'd31) flags_next[0] = 1'b1;
                        6'd4: if (data_byte > 8'd24) flags_next[0] = 1'b1;
                        6'd5: if (data_byte > 8'd60) flags_next[0] = 1'b1;
                        default: left_next = (lane == 3'd0) ? lane_val : (left_reg | lane_val);
                    endcase
                    if (idx_reg < 6'd13) begin
                        idx_next = idx_reg + 6'd1;
                    end else if (flags_next[0]) begin
                        verdict_next = ST_DATE;
                    end else if (left_next != blen_reg - 64'd14) begin
                        verdict_next = ST_CREATOR;
                    end else begin
                        phase_next = (left_next == 64'd0) ? PH_BHDR : PH_CREATOR;
                        idx_next   = 6'd0;
                        flags_next = 2'd0;
                    end
                end
                PH_CREATOR:
                begin
                    left_next = left_dec;
                    if (left_dec == 64'd0) begin
                        phase_next = PH_BHDR;
                        idx_next   = 6'd0;
                        flags_next = 2'd0;
                    end
                end
                PH_ANIM:
                begin
                    if (idx_reg < 6'd7) begin
                        idx_next = idx_reg + 6'd1;
                    end else begin
                        phase_next = PH_CIFF;
                        idx_next   = 6'd0;
                        flags_next = 2'd0;
                    end
                end
                PH_CIFF:
                begin
                    if (idx_reg < 6'd4) begin
                        if (data_byte != CIFF_MAGIC[{idx_reg[1:0], 3'b000} +: 8])
                            flags_next[0] = 1'b1;
                    end else if (idx_reg < 6'd12) begin
                        left_next = (lane == 3'd0) ? lane_val : (left_reg | lane_val);
                    end else if (idx_reg < 6'd20) begin
                        csize_next = (lane == 3'd0) ? lane_val : (csize_reg | lane_val);
                    end else if (idx_reg < 6'd28) begin
                        width_next = (lane == 3'd0) ? lane_val : (width_reg | lane_val);
                    end else begin
                        height_next = (lane == 3'd0) ? lane_val : (height_reg | lane_val);
                        prod_next   = ((lane == 3'd0) ? 64'd0 : prod_reg) + pp;
                    end
                    if (idx_reg < 6'd35) begin
                        idx_next = idx_reg + 6'd1;
                    end else if (flags_next[0]) begin
                        verdict_next = ST_CIFF_MAGIC;
                    end else if (left_reg <= 64'd36) begin
                        verdict_next = ST_CIFF_HSIZE;
                    end else if (csize_reg != prod_next) begin
                        verdict_next = ST_SIZE_MISM;
                    end else if (csize_reg == 64'd0) begin
                        verdict_next = ST_SIZE_ZERO;
                    end else if (left_reg - 64'd36 < 64'd2) begin
                        verdict_next = ST_CIFF_HSIZE;
                    end else begin
                        left_next  = left_reg - 64'd36;
                        phase_next = PH_CAPTION;
                        idx_next   = 6'd0;
                        flags_next = 2'd0;
                    end
                end
                PH_CAPTION:
                begin
                    left_next = left_dec;
                    if (data_byte == NEWLINE) begin
                        if (left_dec == 64'd0) begin
                            left_next  = csize_reg;
                            phase_next = PH_PIXELS;
                        end else begin
                            phase_next = PH_TAGS;
                        end
                        idx_next   = 6'd0;
                        flags_next = 2'd0;
                    end else if (left_dec == 64'd0) begin
                        verdict_next = ST_NO_NEWLINE;
                    end
                end
                PH_TAGS:
                begin
                    if (data_byte == NEWLINE) begin
                        verdict_next = ST_TAG_NEWLINE;
                    end else begin
                        left_next = left_dec;
                        if (left_dec == 64'd0) begin
                            left_next  = csize_reg;
                            phase_next = PH_PIXELS;
                            idx_next   = 6'd0;
                            flags_next = 2'd0;
                        end
                    end
                end
                default:
                begin
                    left_next = left_dec;
                    if (left_dec == 64'd0)
                        verdict_next = ST_ACCEPTED;
                end
            endcase
            status_next = verdict_next;
        end

        if (last_byte && status_next == ST_BUSY)
            status_next = ST_TRUNC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_START;
            idx_reg     <= 6'd0;
            blen_reg    <= 64'd0;
            csize_reg   <= 64'd0;
            width_reg   <= 64'd0;
            height_reg  <= 64'd0;
            prod_reg    <= 64'd0;
            left_reg    <= 64'd0;
            hseen_reg   <= 1'b0;
            flags_reg   <= 2'd0;
            verdict_reg <= ST_BUSY;
            mode_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid)
                mode_reg <= cfg_data;
            if (take) begin
                ovalid_reg <= 1'b1;
                if (last_byte) begin
                    phase_reg   <= PH_START;
                    idx_reg     <= 6'd0;
                    blen_reg    <= 64'd0;
                    csize_reg   <= 64'd0;
                    width_reg   <= 64'd0;
                    height_reg  <= 64'd0;
                    prod_reg    <= 64'd0;
                    left_reg    <= 64'd0;
                    hseen_reg   <= 1'b0;
                    flags_reg   <= 2'd0;
                    verdict_reg <= ST_BUSY;
                end else begin
                    phase_reg   <= phase_next;
                    idx_reg     <= idx_next;
                    blen_reg    <= blen_next;
                    csize_reg   <= csize_next;
                    width_reg   <= width_next;
                    height_reg  <= height_next;
                    prod_reg    <= prod_next;
                    left_reg    <= left_next;
                    hseen_reg   <= hseen_next;
                    flags_reg   <= flags_next;
                    verdict_reg <= verdict_next;
                end
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take) begin
            status_reg <= status_next;
            class_reg  <= class_next;
            tend_reg   <= tend_next;
            ow_reg     <= width_next;
            oh_reg     <= height_next;
        end
    end

endmodule
